// ===== rtl/core/sbpm_pkg.sv =====
// Shared types and constants for the spectrum bar peak meter.
// Used by sbpm_cfg, sbpm_ctrl, sbpm_dp and the top level; no dependencies.
package sbpm_pkg;

    // field widths
    localparam int REQ_W   = 2;
    localparam int BAND_W  = 5;
    localparam int LEVEL_W = 13;
    localparam int STEP_W  = 11;
    localparam int FALL_W  = 8;
    localparam int PIX_W   = 10;
    localparam int SQ_W    = 2 * PIX_W;        // bar_max squared, also quotient width
    localparam int PROD_W  = SQ_W + LEVEL_W;   // bar_max^2 * n

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DECAY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HOLD  = 2'd2;

    // config register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_MIN  = 3'd4;
    localparam int CFG_DATA_W = LEVEL_W;

    // reset values
    localparam logic [LEVEL_W-1:0] RST_FLOOR     = 13'h1A60;   // -1440
    localparam logic [STEP_W-1:0]  RST_DECAY     = 11'd80;
    localparam logic [FALL_W-1:0]  RST_PEAK_FALL = 8'd2;
    localparam logic [PIX_W-1:0]   RST_BAR_MAX   = 10'd138;
    localparam logic [PIX_W-1:0]   RST_SHOW_MIN  = 10'd3;

    // iteration counts: two quotient bits / two root bits per cycle
    localparam int DIV_CYC  = SQ_W / 2;
    localparam int SQRT_CYC = PIX_W / 2;
    localparam int CNT_W    = $clog2(DIV_CYC);

    typedef struct packed {
        logic [LEVEL_W-1:0] floor_level;   // signed
        logic [STEP_W-1:0]  decay_step;
        logic [FALL_W-1:0]  peak_fall;
        logic [PIX_W-1:0]   bar_max;
        logic [PIX_W-1:0]   peak_show_min;
    } t_cfg;

    typedef struct packed {
        logic load_in;   // capture item, read band entry
        logic upd;       // level update
        logic mul1;      // span, n, bar_max^2
        logic mul2;      // product, divider load
        logic div;       // two quotient bits
        logic sqrt;      // two root bits
        logic wr;        // peak update, write back, load result
    } t_cmd;

endpackage

// ===== rtl/core/sbpm_cfg.sv =====
// Configuration register file for the spectrum bar peak meter.
// Depends on sbpm_pkg.
module sbpm_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [sbpm_pkg::CFG_IDX_W-1:0]        i_idx,
    input  logic [sbpm_pkg::CFG_DATA_W-1:0]       i_wdata,
    output sbpm_pkg::t_cfg                        o_cfg
);

    sbpm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_level   <= sbpm_pkg::RST_FLOOR;
            r_cfg.decay_step    <= sbpm_pkg::RST_DECAY;
            r_cfg.peak_fall     <= sbpm_pkg::RST_PEAK_FALL;
            r_cfg.bar_max       <= sbpm_pkg::RST_BAR_MAX;
            r_cfg.peak_show_min <= sbpm_pkg::RST_SHOW_MIN;
        end else if (i_wr_en) begin
            unique case (i_idx)
                sbpm_pkg::CFG_FLOOR:     r_cfg.floor_level   <= i_wdata;
                sbpm_pkg::CFG_DECAY:     r_cfg.decay_step    <= i_wdata[sbpm_pkg::STEP_W-1:0];
                sbpm_pkg::CFG_PEAK_FALL: r_cfg.peak_fall     <= i_wdata[sbpm_pkg::FALL_W-1:0];
                sbpm_pkg::CFG_BAR_MAX:   r_cfg.bar_max       <= i_wdata[sbpm_pkg::PIX_W-1:0];
                sbpm_pkg::CFG_SHOW_MIN:  r_cfg.peak_show_min <= i_wdata[sbpm_pkg::PIX_W-1:0];
                default: ;   // unmapped index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sbpm_ctrl.sv =====
// Sequencer for the spectrum bar peak meter: accepts items, steps the datapath,
// owns the result valid flag. Depends on sbpm_pkg.
module sbpm_ctrl #(
    parameter int BANDS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_valid,
    input  logic [sbpm_pkg::BAND_W-1:0]    i_band,
    output logic                           o_s_ready,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output sbpm_pkg::t_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_MUL1, S_MUL2, S_DIV, S_SQRT, S_WR
    } t_state;

    t_state                        r_state;
    logic [sbpm_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_out_vld;

    logic w_accept;
    logic w_band_ok;
    logic w_out_free;

    assign w_band_ok  = (32'(i_band) < BANDS);
    assign o_s_ready  = (r_state == S_IDLE);
    assign w_accept   = i_s_valid && o_s_ready;
    assign w_out_free = !r_out_vld || i_m_ready;
    assign o_m_valid  = r_out_vld;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load_in = w_accept && w_band_ok;
        o_cmd.upd     = (r_state == S_UPD);
        o_cmd.mul1    = (r_state == S_MUL1);
        o_cmd.mul2    = (r_state == S_MUL2);
        o_cmd.div     = (r_state == S_DIV);
        o_cmd.sqrt    = (r_state == S_SQRT);
        o_cmd.wr      = (r_state == S_WR) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // new result loaded, or the waiting one taken
            if (o_cmd.wr)
                r_out_vld <= 1'b1;
            else if (i_m_ready)
                r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    // out-of-range band: transfer taken and dropped
                    if (w_accept && w_band_ok)
                        r_state <= S_UPD;
                end
                S_UPD:  r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == sbpm_pkg::CNT_W'(sbpm_pkg::DIV_CYC - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == sbpm_pkg::CNT_W'(sbpm_pkg::SQRT_CYC - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_WR;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WR: begin
                    if (w_out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/sbpm_dp.sv =====
// Datapath for the spectrum bar peak meter: band store, level update, multiply,
// radix-4 restoring divider, radix-4 integer square root, peak update, result
// register. Depends on sbpm_pkg.
module sbpm_dp #(
    parameter int BANDS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sbpm_pkg::t_cmd                        i_cmd,
    input  sbpm_pkg::t_cfg                        i_cfg,
    input  logic [sbpm_pkg::REQ_W-1:0]            i_req,
    input  logic [sbpm_pkg::BAND_W-1:0]           i_band,
    input  logic [sbpm_pkg::LEVEL_W-1:0]          i_new_level,
    output logic [sbpm_pkg::BAND_W-1:0]           o_band,
    output logic [sbpm_pkg::LEVEL_W-1:0]          o_level,
    output logic [sbpm_pkg::PIX_W-1:0]            o_bar,
    output logic [sbpm_pkg::PIX_W-1:0]            o_peak,
    output logic                                  o_vis
);

    localparam int LW      = sbpm_pkg::LEVEL_W;
    localparam int PW      = sbpm_pkg::PIX_W;
    localparam int QW      = sbpm_pkg::SQ_W;
    localparam int AW      = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int IW      = (AW > sbpm_pkg::BAND_W) ? AW : sbpm_pkg::BAND_W;
    localparam int ENTRY_W = LW + PW;

    // band store: {level, peak}; valid bits stand in for the reset contents
    logic [ENTRY_W-1:0] r_mem [BANDS];
    logic [BANDS-1:0]   r_vld;
    logic [ENTRY_W-1:0] r_rd;
    logic               r_rd_vld;

    logic [sbpm_pkg::REQ_W-1:0]  r_req;
    logic [sbpm_pkg::BAND_W-1:0] r_band;
    logic [LW-1:0]               r_new_level;
    logic [LW-1:0]               r_lvl;
    logic [LW-1:0]               r_n;
    logic [LW-1:0]               r_d;
    logic                        r_zero;
    logic [QW-1:0]               r_bm2;
    logic [LW-1:0]               r_rem;
    logic [QW-1:0]               r_quo;
    logic [PW:0]                 r_sq_rem;
    logic [PW-1:0]               r_sq_res;

    logic [IW-1:0] w_in_ext, w_wr_ext;
    logic [AW-1:0] w_rd_addr, w_wr_addr;

    assign w_in_ext  = IW'(i_band);
    assign w_wr_ext  = IW'(r_band);
    assign w_rd_addr = w_in_ext[AW-1:0];
    assign w_wr_addr = w_wr_ext[AW-1:0];

    // ---- level update
    logic signed [LW-1:0] w_floor, w_cur, w_new_in, w_lvl_new;
    logic signed [LW:0]   w_floor14, w_dec14;
    logic [PW-1:0]        w_peak_old;

    assign w_floor    = $signed(i_cfg.floor_level);
    assign w_floor14  = (LW+1)'(w_floor);
    assign w_cur      = r_rd_vld ? $signed(r_rd[ENTRY_W-1 -: LW]) : $signed(sbpm_pkg::RST_FLOOR);
    assign w_peak_old = r_rd_vld ? r_rd[PW-1:0] : '0;
    assign w_new_in   = $signed(r_new_level);
    assign w_dec14    = (LW+1)'(w_cur) - $signed({3'b000, i_cfg.decay_step});

    always_comb begin
        w_lvl_new = w_cur;
        case (r_req)
            sbpm_pkg::REQ_LOAD: begin
                w_lvl_new = w_new_in;
                if (w_lvl_new > 0)
                    w_lvl_new = '0;
                if (w_lvl_new < w_floor)
                    w_lvl_new = w_floor;
            end
            sbpm_pkg::REQ_DECAY: begin
                if (w_dec14 < w_floor14)
                    w_lvl_new = w_floor;
                else
                    w_lvl_new = w_dec14[LW-1:0];
            end
            default: w_lvl_new = w_cur;   // hold, also the unused code
        endcase
    end

    // ---- span and clamped numerator
    logic signed [LW:0] w_n14, w_d14;
    logic [LW-1:0]      w_n;

    assign w_n14 = (LW+1)'($signed(r_lvl)) - w_floor14;
    assign w_d14 = -w_floor14;

    always_comb begin
        if (w_n14 < 0)
            w_n = '0;
        else if (w_n14 > w_d14)
            w_n = w_d14[LW-1:0];
        else
            w_n = w_n14[LW-1:0];
    end

    logic [sbpm_pkg::PROD_W-1:0] w_prod;
    assign w_prod = sbpm_pkg::PROD_W'(r_bm2) * sbpm_pkg::PROD_W'(r_n);

    // ---- divider, two restoring steps per cycle
    logic [LW:0]   w_s1, w_s2;
    logic          w_b1, w_b2;
    logic [LW-1:0] w_rem1, w_rem2;

    assign w_s1   = {r_rem, r_quo[QW-1]};
    assign w_b1   = (w_s1 >= {1'b0, r_d});
    assign w_rem1 = w_b1 ? LW'(w_s1 - {1'b0, r_d}) : w_s1[LW-1:0];
    assign w_s2   = {w_rem1, r_quo[QW-2]};
    assign w_b2   = (w_s2 >= {1'b0, r_d});
    assign w_rem2 = w_b2 ? LW'(w_s2 - {1'b0, r_d}) : w_s2[LW-1:0];

    // ---- square root, two result bits per cycle
    logic [PW+2:0] w_x1, w_t1, w_x2, w_t2;
    logic          w_g1, w_g2;
    logic [PW:0]   w_sr1, w_sr2;
    logic [PW-1:0] w_res1;

    assign w_x1   = {r_sq_rem, r_quo[QW-1 -: 2]};
    assign w_t1   = {1'b0, r_sq_res, 2'b01};
    assign w_g1   = (w_x1 >= w_t1);
    assign w_sr1  = w_g1 ? (PW+1)'(w_x1 - w_t1) : w_x1[PW:0];
    assign w_res1 = {r_sq_res[PW-2:0], w_g1};
    assign w_x2   = {w_sr1, r_quo[QW-3 -: 2]};
    assign w_t2   = {1'b0, w_res1, 2'b01};
    assign w_g2   = (w_x2 >= w_t2);
    assign w_sr2  = w_g2 ? (PW+1)'(w_x2 - w_t2) : w_x2[PW:0];

    // ---- peak
    logic [PW-1:0] w_bar, w_peak_new;

    assign w_bar = r_zero ? '0 : r_sq_res;

    always_comb begin
        if (w_peak_old < w_bar)
            w_peak_new = w_bar;
        else if (w_peak_old > PW'(i_cfg.peak_fall))
            w_peak_new = w_peak_old - PW'(i_cfg.peak_fall);
        else
            w_peak_new = '0;
    end

    // ---- store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in)
            r_rd <= r_mem[w_rd_addr];
        if (i_cmd.wr)
            r_mem[w_wr_addr] <= {r_lvl, w_peak_new};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req       <= i_req;
            r_band      <= i_band;
            r_new_level <= i_new_level;
            r_rd_vld    <= r_vld[w_rd_addr];
        end
        if (i_cmd.upd)
            r_lvl <= w_lvl_new;
        if (i_cmd.mul1) begin
            r_n    <= w_n;
            r_d    <= w_d14[LW-1:0];
            r_zero <= (w_d14 <= 0);
            r_bm2  <= QW'(i_cfg.bar_max) * QW'(i_cfg.bar_max);
        end
        if (i_cmd.mul2) begin
            // quotient fits QW bits since n <= d, so the top part is below d
            r_rem    <= w_prod[sbpm_pkg::PROD_W-1 -: LW];
            r_quo    <= w_prod[QW-1:0];
            r_sq_rem <= '0;
            r_sq_res <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= w_rem2;
            r_quo <= {r_quo[QW-3:0], w_b1, w_b2};
        end
        if (i_cmd.sqrt) begin
            r_sq_rem <= w_sr2;
            r_sq_res <= {w_res1[PW-2:0], w_g2};
            r_quo    <= {r_quo[QW-5:0], 4'b0000};
        end
        if (i_cmd.wr) begin
            o_band  <= r_band;
            o_level <= r_lvl;
            o_bar   <= w_bar;
            o_peak  <= w_peak_new;
            o_vis   <= (w_peak_new >= i_cfg.peak_show_min);
        end
    end

endmodule

// ===== rtl/core/spectrum_bar_peak_meter_top.sv =====
// Spectrum bar peak meter, top level: configuration registers, sequencer and
// datapath. Depends on sbpm_pkg, sbpm_cfg, sbpm_ctrl, sbpm_dp.
//
// Per-band level meter with peak hold for a spectrum display. Each input
// transfer names a band and a request (load, decay, hold); the block keeps a
// level (1/16 dB) and a peak marker (pixels) per band and returns one result
// per transfer: the stored level, the bar length
// floor(bar_max * sqrt((level - floor) / -floor)) and the updated peak with
// its visibility flag. Transfers naming a band at or above BANDS are taken
// and dropped without a result. One item occupies the block from its input
// transfer to the cycle it can take the next one: the band store read, the
// level update, two multiply stages, the radix-4 divider, the radix-4 square
// root, and peak update and write-back. The result sits in an output
// register; the next item is accepted while it waits, and only the final
// write-back stalls until the previous result is taken. Band state comes up
// at silence and zero peak out of reset with no clearing pass. Configuration
// writes take effect on the next edge and are meant for idle periods.
module spectrum_bar_peak_meter_top #(
    parameter int BANDS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [4:0] band, [17:5] new_level, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] out_band, [17:5] shown_level,
                                        // [27:18] bar_length, [37:28] peak_value,
                                        // [38] peak_visible, [39] zero
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_wdata
);

    sbpm_pkg::t_cfg w_cfg;
    sbpm_pkg::t_cmd w_cmd;

    logic [sbpm_pkg::BAND_W-1:0]  w_band;
    logic [sbpm_pkg::LEVEL_W-1:0] w_level;
    logic [sbpm_pkg::PIX_W-1:0]   w_bar;
    logic [sbpm_pkg::PIX_W-1:0]   w_peak;
    logic                         w_vis;

    sbpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // sequencer sees the band field directly to drop out-of-range transfers
    sbpm_ctrl #(
        .BANDS (BANDS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_band    (s_axis_tdata[4:0]),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd)
    );

    sbpm_dp #(
        .BANDS (BANDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_req       (s_axis_tuser),
        .i_band      (s_axis_tdata[4:0]),
        .i_new_level (s_axis_tdata[17:5]),
        .o_band      (w_band),
        .o_level     (w_level),
        .o_bar       (w_bar),
        .o_peak      (w_peak),
        .o_vis       (w_vis)
    );

    // pack result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {1'b0, w_vis, w_peak, w_bar, w_level, w_band};

endmodule

// ===== dv/sbpm_checker.sv =====
// Result checker for the spectrum bar peak meter: follows both streams and the
// config port, predicts one result per in-range transfer and compares in order.
// Depends on sbpm_pkg for request codes and register indexes.
module sbpm_checker #(
    parameter int BANDS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,    // [4:0] band, [17:5] new_level
    input  logic [1:0]  i_s_tuser,    // [1:0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // [4:0] band, [17:5] level, [27:18] bar,
                                      // [37:28] peak, [38] visible
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // laid out like the result bus, highest field first
    typedef struct packed {
        logic        visible;
        logic [9:0]  peak;
        logic [9:0]  bar;
        logic [12:0] level;
        logic [4:0]  band;
    } t_meter_reading;

    t_meter_reading readings_q[$];

    // shadow of the meter configuration and band store
    int floor_db;
    int drop_step;
    int fall_px;
    int bar_max_px;
    int show_min_px;
    int level_mem[BANDS];
    int peak_mem[BANDS];
    int mismatch_cnt;

    function automatic longint int_sqrt(longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // floor(bar_max * sqrt(ratio)), ratio clamped to [0,1]
    function automatic int bar_length_of(int lvl);
        longint span;
        longint n;
        longint q;
        span = -floor_db;
        if (span <= 0)
            return 0;
        n = lvl - floor_db;
        if (n < 0)
            n = 0;
        if (n > span)
            n = span;
        q = longint'(bar_max_px) * bar_max_px * n / span;
        return int'(int_sqrt(q)) & 'h3FF;
    endfunction

    function automatic t_meter_reading apply_request(logic [1:0] req, int band, int new_lvl);
        t_meter_reading r;
        int lvl;
        int bar;
        int pk;
        lvl = level_mem[band];
        if (req == sbpm_pkg::REQ_LOAD) begin
            lvl = new_lvl;
            if (lvl > 0)
                lvl = 0;
            if (lvl < floor_db)
                lvl = floor_db;
        end else if (req == sbpm_pkg::REQ_DECAY) begin
            lvl = lvl - drop_step;
            if (lvl < floor_db)
                lvl = floor_db;
        end
        level_mem[band] = lvl;
        bar = bar_length_of(lvl);
        pk = peak_mem[band];
        if (pk < bar)
            pk = bar;
        else
            pk = (pk > fall_px) ? pk - fall_px : 0;
        pk = pk & 'h3FF;
        peak_mem[band] = pk;
        r.band    = band[4:0];
        r.level   = lvl[12:0];
        r.bar     = bar[9:0];
        r.peak    = pk[9:0];
        r.visible = (pk >= show_min_px);
        return r;
    endfunction

    task automatic check_field(string name, int band, int want, int got);
        if (want != got) begin
            mismatch_cnt++;
            $display("%0t: band %0d %s expected %0d actual %0d",
                     $time, band, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_meter_reading want;
        t_meter_reading got;
        if (!i_rst_n) begin
            floor_db    = -1440;
            drop_step   = 80;
            fall_px     = 2;
            bar_max_px  = 138;
            show_min_px = 3;
            for (int i = 0; i < BANDS; i++) begin
                level_mem[i] = -1440;
                peak_mem[i]  = 0;
            end
            readings_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    sbpm_pkg::CFG_FLOOR:     floor_db    = int'($signed(i_cfg_wdata));
                    sbpm_pkg::CFG_DECAY:     drop_step   = int'(i_cfg_wdata[10:0]);
                    sbpm_pkg::CFG_PEAK_FALL: fall_px     = int'(i_cfg_wdata[7:0]);
                    sbpm_pkg::CFG_BAR_MAX:   bar_max_px  = int'(i_cfg_wdata[9:0]);
                    sbpm_pkg::CFG_SHOW_MIN:  show_min_px = int'(i_cfg_wdata[9:0]);
                    default: ;
                endcase
            end
            // result side first: a result never belongs to a same-edge input
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[38:0];
                if (readings_q.size() == 0) begin
                    mismatch_cnt++;
                    $display({"%0t: expected no result, actual band %0d level %0d",
                              " bar %0d peak %0d"},
                             $time, got.band, $signed(got.level), got.bar, got.peak);
                end else begin
                    want = readings_q.pop_front();
                    check_field("band", want.band, want.band, got.band);
                    check_field("level", want.band, $signed(want.level), $signed(got.level));
                    check_field("bar", want.band, want.bar, got.bar);
                    check_field("peak", want.band, want.peak, got.peak);
                    check_field("visible", want.band, want.visible, got.visible);
                end
            end
            if (i_s_tvalid && i_s_tready && i_s_tdata[4:0] < BANDS)
                readings_q.push_back(apply_request(i_s_tuser, int'(i_s_tdata[4:0]),
                                                   int'($signed(i_s_tdata[17:5]))));
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= readings_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the spectrum bar peak meter: clock, reset, stimulus on the
// input stream and config port, result backpressure, watchdog and verdict.
// Depends on sbpm_pkg, spectrum_bar_peak_meter_top and sbpm_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANDS = 24;
    // request code 3 has no function of its own; the meter treats it as hold
    localparam logic [sbpm_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 210;
    // dropped items give no result, so wait this long after the last result
    // before touching config
    localparam int DRAIN_CYCLES    = 30;
    // longest legal quiet stretch is a long source gap plus a long sink stall
    // plus the pipeline, well under this
    localparam int STALL_LIMIT     = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // [4:0] band, [17:5] new_level, rest zero
    logic [1:0]  s_axis_tuser;    // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [4:0] out_band, [17:5] shown_level,
                                  // [27:18] bar_length, [37:28] peak_value,
                                  // [38] peak_visible, [39] zero
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_idx;
    logic [12:0] i_cfg_wdata;

    int mismatches;
    int outstanding;
    int idle_cycles;

    // stimulus shaping, changed per phase
    int cur_floor = -1440;   // floor the meter runs with, steers level picks
    int band_top  = BANDS - 1;
    bit src_steady;          // no source gaps this phase
    bit snk_steady;          // no sink stalls this phase

    spectrum_bar_peak_meter_top #(
        .BANDS (BANDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    sbpm_checker #(
        .BANDS (BANDS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly back to back or short, now and then a long pause
    function automatic int gap_len(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input transfer; valid stays up across back-to-back items
    task automatic send_item(input logic [1:0] req, input int band, input int lvl);
        int gap;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {6'd0, 13'(lvl), 5'(band)};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = gap_len(src_steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let the block go idle: all results back, plus room for a dropped item
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic program_meter(input int fl, input int dec, input int fall,
                                 input int bmax, input int show);
        cur_floor = fl;
        write_reg(sbpm_pkg::CFG_FLOOR, 13'(fl));
        write_reg(sbpm_pkg::CFG_DECAY, 13'(dec));
        write_reg(sbpm_pkg::CFG_PEAK_FALL, 13'(fall));
        write_reg(sbpm_pkg::CFG_BAR_MAX, 13'(bmax));
        write_reg(sbpm_pkg::CFG_SHOW_MIN, 13'(show));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random band traffic. Most levels land inside the current span so the
    // bar actually moves; some sit right at the floor or at 0 dB, the rest
    // cover the whole 13-bit field. A few transfers name bands past the end;
    // those are dropped by the block and not counted.
    task automatic random_traffic(input int count);
        int sent;
        int band;
        int lvl;
        int r;
        logic [1:0] req;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            band = (r < 7) ? int'($urandom_range(BANDS, 31)) : int'($urandom_range(0, band_top));
            r = $urandom_range(0, 99);
            req = (r < 40) ? sbpm_pkg::REQ_LOAD :
                  (r < 70) ? sbpm_pkg::REQ_DECAY :
                  (r < 90) ? sbpm_pkg::REQ_HOLD : REQ_SPARE;
            r = $urandom_range(0, 99);
            if (r < 55 && cur_floor < 0)
                lvl = cur_floor - 48 + int'($urandom_range(0, 80 - cur_floor));
            else if (r < 70)
                lvl = ($urandom_range(0, 1) != 0) ? cur_floor + int'($urandom_range(0, 4)) - 2
                                                  : int'($urandom_range(0, 4)) - 2;
            else
                lvl = int'($urandom_range(0, 8191)) - 4096;
            send_item(req, band, lvl);
            if (band < BANDS)
                sent++;
        end
    endtask

    // result side backpressure
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = gap_len(snk_steady);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // watchdog: any transfer or config write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= sbpm_pkg::REQ_LOAD;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_idx     <= sbpm_pkg::CFG_FLOOR;
        i_cfg_wdata   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration (floor -90 dB, 138 px bar).
        send_item(sbpm_pkg::REQ_HOLD, 5, 0);       // untouched band: silence, zero peak
        send_item(sbpm_pkg::REQ_LOAD, 0, 0);       // full scale, peak jumps to bar
        send_item(sbpm_pkg::REQ_HOLD, 0, 0);       // bar not above peak: peak falls
        send_item(sbpm_pkg::REQ_DECAY, 0, 0);
        send_item(REQ_SPARE, 0, -4096);            // spare code behaves as hold
        send_item(sbpm_pkg::REQ_LOAD, 23, -4096);  // most negative field value -> floor
        send_item(sbpm_pkg::REQ_LOAD, 23, 4095);   // most positive field value -> 0 dB
        send_item(sbpm_pkg::REQ_LOAD, 1, -1440);   // exactly at floor
        send_item(sbpm_pkg::REQ_LOAD, 1, -1441);   // just under floor
        send_item(sbpm_pkg::REQ_DECAY, 1, 0);      // decay already at floor
        send_item(sbpm_pkg::REQ_LOAD, 2, 1);       // just over 0 dB
        send_item(sbpm_pkg::REQ_LOAD, 2, -1);
        send_item(sbpm_pkg::REQ_LOAD, 3, -1439);   // one step above floor, tiny bar
        send_item(sbpm_pkg::REQ_LOAD, BANDS, 0);   // band past the end: dropped
        send_item(sbpm_pkg::REQ_DECAY, 31, -1);    // highest band code: dropped
        send_item(sbpm_pkg::REQ_LOAD, 16, -720);
        repeat (6)
            send_item(sbpm_pkg::REQ_DECAY, 16, 0); // walk down toward floor, peak trails
        send_item(sbpm_pkg::REQ_HOLD, 16, 4095);   // level field ignored on hold
        random_traffic(ITEMS_PER_PHASE);
        drain();

        for (int p = 1; p < N_PHASES; p++) begin
            case (p)
                1: program_meter(-3200, 1600, 255, 1023, 1023);   // upper extremes
                2: program_meter(-16, 0, 0, 1, 0);                // lower extremes
                3: program_meter(0, 5, 1, 50, 2);                 // floor at 0: no span
                4: program_meter(200, 300, 7, 0, 0);              // floor above 0, no bar
                5: program_meter(-1440, 80, 2, 138, 3);           // back to defaults
                default:
                    program_meter(-int'($urandom_range(16, 3200)),
                                  $urandom_range(0, 1600), $urandom_range(0, 255),
                                  $urandom_range(1, 1023), $urandom_range(0, 1023));
            endcase
            // some phases hammer a few bands so peaks climb and fall all the way
            band_top   = ($urandom_range(0, 2) == 0) ? 3 : BANDS - 1;
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            random_traffic(ITEMS_PER_PHASE);
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== spectrum_bar_peak_meter_top.f =====
rtl/core/sbpm_pkg.sv
rtl/core/sbpm_cfg.sv
rtl/core/sbpm_ctrl.sv
rtl/core/sbpm_dp.sv
rtl/core/spectrum_bar_peak_meter_top.sv
dv/sbpm_checker.sv
dv/tb.sv
